FILE: sv/rsca_pkg.sv
// ----------------------------------------------------------------------------
// rsca_pkg
// Shared types and codes for the send queue credit admission block.
// ----------------------------------------------------------------------------
package rsca_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int KW          = $clog2(MAX_RESULTS + 1);
  // ring wrap bound; the ring slot is 10 bits wide, so this cannot grow
  localparam int MAX_DEPTH   = 1024;

  typedef enum logic [1:0] {
    OP_ADMIT   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ERROR   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    VERB_SEND  = 2'd0,
    VERB_WRITE = 2'd1,
    VERB_READ  = 2'd2
  } verb_t;

  typedef enum logic [1:0] {
    KIND_SUBMIT  = 2'd0,
    KIND_FLUSH   = 2'd1,
    KIND_REFUSED = 2'd2
  } kind_t;

  localparam logic [1:0] REG_QUEUE_DEPTH  = 2'd0;
  localparam logic [1:0] REG_READ_WINDOW  = 2'd1;
  localparam logic [1:0] REG_INLINE_LIMIT = 2'd2;

  localparam logic [10:0] QUEUE_DEPTH_RST  = 11'd128;
  localparam logic [10:0] READ_WINDOW_RST  = 11'd16;
  localparam logic [15:0] INLINE_LIMIT_RST = 16'd64;

  typedef struct packed {
    logic [47:0] tag;
    logic [31:0] length;
    logic [63:0] address;
    logic [31:0] key;
    verb_t       verb;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] tag;
    verb_t       verb;
    logic [9:0]  slot;
    logic        inline_flag;
    logic        has_data;
    logic [31:0] length;
    logic [63:0] address;
    logic [31:0] key;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [10:0] in_flight;
    logic [10:0] reads_in_flight;
    logic [9:0]  ring_position;
    logic [10:0] queue_depth;
    logic [10:0] read_window;
  } credit_in_t;

  typedef struct packed {
    logic       total_ok;
    logic       read_ok;
    logic [9:0] ring_next;
  } credit_out_t;

endpackage

FILE: sv/rsca_fifo.sv
// ----------------------------------------------------------------------------
// rsca_fifo
// Parking queue for requests that found no credit; registered read port.
// ----------------------------------------------------------------------------
module rsca_fifo #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  rsca_pkg::req_t                     push_data,
  input  logic                               pop,
  output rsca_pkg::req_t                     pop_data,
  output logic [$clog2(WAIT_DEPTH+1)-1:0]    count
);

  localparam int IW = $clog2(WAIT_DEPTH);
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam int SW = IW + 1;

  rsca_pkg::req_t mem [WAIT_DEPTH];
  logic [IW-1:0]  head;
  logic [IW-1:0]  tail;
  logic [SW-1:0]  tail_sum;

  always_comb begin
    tail_sum = {1'b0, head} + SW'(count);
    if (tail_sum >= SW'(WAIT_DEPTH)) begin
      tail = IW'(tail_sum - SW'(WAIT_DEPTH));
    end else begin
      tail = IW'(tail_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (pop) begin
      pop_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= (head == IW'(WAIT_DEPTH - 1)) ? '0 : head + IW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

FILE: sv/rsca_credit.sv
// ----------------------------------------------------------------------------
// rsca_credit
// Shared credit compare and ring slot advance used by admit and drain.
// ----------------------------------------------------------------------------
module rsca_credit (
  input  rsca_pkg::credit_in_t  cin,
  output rsca_pkg::credit_out_t cout
);

  logic [10:0] next_pos;
  logic        wrap;

  always_comb begin
    next_pos      = {1'b0, cin.ring_position} + 11'd1;
    wrap          = (next_pos == cin.queue_depth) ||
                    ({21'b0, next_pos} >= 32'(rsca_pkg::MAX_DEPTH));
    cout.total_ok  = cin.in_flight < cin.queue_depth;
    cout.read_ok   = cin.reads_in_flight < cin.read_window;
    cout.ring_next = wrap ? 10'd0 : next_pos[9:0];
  end

endmodule

FILE: sv/rdma_send_credit_admission.sv
// ----------------------------------------------------------------------------
// rdma_send_credit_admission
// Slot-credit admission for a send queue with read and normal parking queues.
// ----------------------------------------------------------------------------
// Admit: the item is latched on accept, then decided and, unless it is parked,
//   registered into the result register; no new item is taken until idle again.
// Release: credits settle first, then, unless the queue is broken, each drained
//   item takes a queue read, then a result step; the queue read is registered.
// Error: the queue is marked broken, then each parked item is popped and flushed
//   as a result; items past the result cap are dropped unreported.
// Reset clears credits, ring position, broken flag, queue pointers and the
//   configuration registers to their defaults; queue contents are not cleared.
module rdma_send_credit_admission #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [1:0]  verb,
  input  logic [47:0] request_tag,
  input  logic [31:0] local_length,
  input  logic [63:0] remote_address,
  input  logic [31:0] remote_key,
  input  logic [10:0] release_count,
  input  logic [10:0] release_reads,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [47:0] out_tag,
  output logic [1:0]  out_verb,
  output logic [9:0]  ring_slot,
  output logic        inline_flag,
  output logic        has_data,
  output logic [31:0] out_length,
  output logic [63:0] out_remote_address,
  output logic [31:0] out_remote_key,
  output logic        last
);

  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam int KW = rsca_pkg::KW;

  // One-hot sequencer: decide an item, then walk the parking queues.
  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_ADMIT     = 6'b000010,
    S_CHECK     = 6'b000100,
    S_FETCH     = 6'b001000,
    S_ERR_POP   = 6'b010000,
    S_ERR_FETCH = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [10:0] queue_depth, read_window;
  logic [15:0] inline_limit;

  // latched item
  rsca_pkg::op_t  item_op, item_op_next;
  rsca_pkg::req_t req, req_next;
  logic [10:0]    rel_count, rel_count_next;
  logic [10:0]    rel_reads, rel_reads_next;

  // credit state
  logic [10:0] in_flight, in_flight_next;
  logic [10:0] reads_in_flight, reads_in_flight_next;
  logic [9:0]  ring_position, ring_position_next;
  logic        broken, broken_next;

  // drain bookkeeping
  logic [KW-1:0] k, k_next;
  logic [KW-1:0] err_total, err_total_next;
  logic          src_read, src_read_next;

  // result register
  rsca_pkg::res_t out_res;
  rsca_pkg::res_t load_res;
  logic           load;
  logic           out_free;

  // parking queues
  logic           rd_push, rd_pop, nm_push, nm_pop;
  rsca_pkg::req_t rd_data, nm_data, popped;
  logic [CW-1:0]  rd_count, nm_count;
  logic           rd_full, nm_full;

  // shared credit unit
  rsca_pkg::credit_in_t  cu_in;
  rsca_pkg::credit_out_t cu_out;

  logic           rd_can, nm_can, more, item_ok;
  logic [CW:0]    park_sum;
  rsca_pkg::verb_t verb_in;

  rsca_fifo #(.WAIT_DEPTH(WAIT_DEPTH)) u_rd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_push),
    .push_data (req),
    .pop       (rd_pop),
    .pop_data  (rd_data),
    .count     (rd_count)
  );

  rsca_fifo #(.WAIT_DEPTH(WAIT_DEPTH)) u_nm_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (nm_push),
    .push_data (req),
    .pop       (nm_pop),
    .pop_data  (nm_data),
    .count     (nm_count)
  );

  rsca_credit u_credit (
    .cin  (cu_in),
    .cout (cu_out)
  );

  // Build one result; failed and refused items carry only tag and verb.
  function automatic rsca_pkg::res_t build_res(
    input rsca_pkg::kind_t k_kind,
    input rsca_pkg::req_t  r,
    input logic [9:0]      slot,
    input logic [15:0]     lim,
    input logic            is_last
  );
    rsca_pkg::res_t res;
    logic           full;
    logic           remote;
    full            = (k_kind == rsca_pkg::KIND_SUBMIT);
    remote          = full && (r.verb != rsca_pkg::VERB_SEND);
    res.kind        = k_kind;
    res.tag         = r.tag;
    res.verb        = r.verb;
    res.slot        = full ? slot : '0;
    res.inline_flag = full && (r.verb != rsca_pkg::VERB_READ) &&
                      (r.length <= {16'b0, lim});
    res.has_data    = full && (r.length != '0);
    res.length      = full ? r.length : '0;
    res.address     = remote ? r.address : '0;
    res.key         = remote ? r.key : '0;
    res.last        = is_last;
    return res;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign rd_full  = (rd_count == CW'(WAIT_DEPTH));
  assign nm_full  = (nm_count == CW'(WAIT_DEPTH));
  assign popped   = src_read ? rd_data : nm_data;
  assign verb_in  = (verb == 2'd3) ? rsca_pkg::VERB_WRITE : rsca_pkg::verb_t'(verb);

  always_comb begin
    cu_in.in_flight       = in_flight;
    cu_in.reads_in_flight = reads_in_flight;
    cu_in.ring_position   = ring_position;
    cu_in.queue_depth     = queue_depth;
    cu_in.read_window     = read_window;
  end

  // Reads drain first; a read that is blocked stays blocked for this release.
  assign rd_can   = (rd_count != '0) && cu_out.total_ok && cu_out.read_ok;
  assign nm_can   = (nm_count != '0) && cu_out.total_ok;
  assign more     = (rd_can || nm_can) && ((k + KW'(1)) != KW'(rsca_pkg::MAX_RESULTS));
  assign item_ok  = (req.verb == rsca_pkg::VERB_READ) ?
                    (cu_out.total_ok && cu_out.read_ok) : cu_out.total_ok;
  assign park_sum = (CW+1)'(rd_count) + (CW+1)'(nm_count);

  always_comb begin
    state_next           = state;
    item_op_next         = item_op;
    req_next             = req;
    rel_count_next       = rel_count;
    rel_reads_next       = rel_reads;
    in_flight_next       = in_flight;
    reads_in_flight_next = reads_in_flight;
    ring_position_next   = ring_position;
    broken_next          = broken;
    k_next               = k;
    err_total_next       = err_total;
    src_read_next        = src_read;
    load                 = 1'b0;
    load_res             = out_res;
    rd_push              = 1'b0;
    nm_push              = 1'b0;
    rd_pop               = 1'b0;
    nm_pop               = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_op_next   = rsca_pkg::op_t'(op);
          req_next.tag     = request_tag;
          req_next.length  = local_length;
          req_next.address = remote_address;
          req_next.key     = remote_key;
          req_next.verb    = verb_in;
          rel_count_next = release_count;
          rel_reads_next = release_reads;
          state_next     = S_ADMIT;
        end
      end

      S_ADMIT: begin
        case (item_op)
          rsca_pkg::OP_ADMIT: begin
            if (broken) begin
              // broken queue: fail at once
              if (out_free) begin
                load       = 1'b1;
                load_res   = build_res(rsca_pkg::KIND_FLUSH, req, '0, inline_limit, 1'b1);
                state_next = S_IDLE;
              end
            end else if (item_ok) begin
              if (out_free) begin
                load               = 1'b1;
                load_res           = build_res(rsca_pkg::KIND_SUBMIT, req, ring_position,
                                               inline_limit, 1'b1);
                in_flight_next     = in_flight + 11'd1;
                if (req.verb == rsca_pkg::VERB_READ) begin
                  reads_in_flight_next = reads_in_flight + 11'd1;
                end
                ring_position_next = cu_out.ring_next;
                state_next         = S_IDLE;
              end
            end else if ((req.verb == rsca_pkg::VERB_READ) ? rd_full : nm_full) begin
              // no room to park: refuse
              if (out_free) begin
                load       = 1'b1;
                load_res   = build_res(rsca_pkg::KIND_REFUSED, req, '0, inline_limit, 1'b1);
                state_next = S_IDLE;
              end
            end else begin
              // park silently
              rd_push    = (req.verb == rsca_pkg::VERB_READ);
              nm_push    = (req.verb != rsca_pkg::VERB_READ);
              state_next = S_IDLE;
            end
          end
          rsca_pkg::OP_RELEASE: begin
            // clamp returned credits to what is outstanding
            in_flight_next       = in_flight -
                                   ((rel_count > in_flight) ? in_flight : rel_count);
            reads_in_flight_next = reads_in_flight -
                                   ((rel_reads > reads_in_flight) ? reads_in_flight : rel_reads);
            k_next               = '0;
            state_next           = broken ? S_IDLE : S_CHECK;
          end
          rsca_pkg::OP_ERROR: begin
            broken_next    = 1'b1;
            k_next         = '0;
            err_total_next = (int'(park_sum) >= rsca_pkg::MAX_RESULTS) ?
                             KW'(rsca_pkg::MAX_RESULTS) : KW'(park_sum);
            state_next     = S_ERR_POP;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_CHECK: begin
        if (rd_can) begin
          rd_pop               = 1'b1;
          src_read_next        = 1'b1;
          in_flight_next       = in_flight + 11'd1;
          reads_in_flight_next = reads_in_flight + 11'd1;
          state_next           = S_FETCH;
        end else if (nm_can) begin
          nm_pop         = 1'b1;
          src_read_next  = 1'b0;
          in_flight_next = in_flight + 11'd1;
          state_next     = S_FETCH;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_FETCH: begin
        // credits already taken; look ahead to mark the final result
        if (out_free) begin
          load               = 1'b1;
          load_res           = build_res(rsca_pkg::KIND_SUBMIT, popped, ring_position,
                                         inline_limit, !more);
          ring_position_next = cu_out.ring_next;
          k_next             = k + KW'(1);
          state_next         = more ? S_CHECK : S_IDLE;
        end
      end

      S_ERR_POP: begin
        if (rd_count != '0) begin
          rd_pop        = 1'b1;
          src_read_next = 1'b1;
          state_next    = S_ERR_FETCH;
        end else if (nm_count != '0) begin
          nm_pop        = 1'b1;
          src_read_next = 1'b0;
          state_next    = S_ERR_FETCH;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_ERR_FETCH: begin
        if (k < KW'(rsca_pkg::MAX_RESULTS)) begin
          if (out_free) begin
            load       = 1'b1;
            load_res   = build_res(rsca_pkg::KIND_FLUSH, popped, '0, inline_limit,
                                   (k + KW'(1)) == err_total);
            k_next     = k + KW'(1);
            state_next = S_ERR_POP;
          end
        end else begin
          // past the result cap: drop unreported
          state_next = S_ERR_POP;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      in_flight       <= '0;
      reads_in_flight <= '0;
      ring_position   <= '0;
      broken          <= 1'b0;
      k               <= '0;
      err_total       <= '0;
      out_valid       <= 1'b0;
      queue_depth     <= rsca_pkg::QUEUE_DEPTH_RST;
      read_window     <= rsca_pkg::READ_WINDOW_RST;
      inline_limit    <= rsca_pkg::INLINE_LIMIT_RST;
    end else begin
      state           <= state_next;
      in_flight       <= in_flight_next;
      reads_in_flight <= reads_in_flight_next;
      ring_position   <= ring_position_next;
      broken          <= broken_next;
      k               <= k_next;
      err_total       <= err_total_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          rsca_pkg::REG_QUEUE_DEPTH:  queue_depth  <= cfg_data[10:0];
          rsca_pkg::REG_READ_WINDOW:  read_window  <= cfg_data[10:0];
          rsca_pkg::REG_INLINE_LIMIT: inline_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_op   <= item_op_next;
    req       <= req_next;
    rel_count <= rel_count_next;
    rel_reads <= rel_reads_next;
    src_read  <= src_read_next;
    if (load) begin
      out_res <= load_res;
    end
  end

  assign kind               = out_res.kind;
  assign out_tag            = out_res.tag;
  assign out_verb           = out_res.verb;
  assign ring_slot          = out_res.slot;
  assign inline_flag        = out_res.inline_flag;
  assign has_data           = out_res.has_data;
  assign out_length         = out_res.length;
  assign out_remote_address = out_res.address;
  assign out_remote_key     = out_res.key;
  assign last               = out_res.last;

endmodule
